// ===== design/assert_macros.svh =====
// Assertion macros used by the list core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_AT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition is never true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_AT(label, !(cond), msg)

`endif

// ===== design/alc_pkg.sv =====
// Types and constants of the array list with cursor.
package alc_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W = 5;
	localparam int POS_W = 4;

	typedef enum logic [2:0] {
		CMD_CLEAR  = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_APPEND = 3'd2,
		CMD_REMOVE = 3'd3,
		CMD_NEXT   = 3'd4,
		CMD_PREV   = 3'd5,
		CMD_SETPOS = 3'd6,
		CMD_READ   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_APPEND,
		OP_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [POS_W-1:0]   cursor;
		logic [CNT_W-1:0]   count;
	} cell_ctl_t;

endpackage

// ===== design/alc_cell.sv =====
// One storage cell of the list chain, holding the entry at a fixed index.
module alc_cell #(
	parameter int INDEX = 0,
	parameter int WORD_WIDTH = 32
) (
	input  logic                  clk,
	input  alc_pkg::cell_ctl_t    ctl,
	input  logic [WORD_WIDTH-1:0] new_word,
	input  logic [WORD_WIDTH-1:0] prev_word,
	input  logic [WORD_WIDTH-1:0] next_word,
	output logic [WORD_WIDTH-1:0] word
);
	import alc_pkg::*;

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

	logic [WORD_WIDTH-1:0] word_q;
	logic [WORD_WIDTH-1:0] word_d;
	logic [CNT_W-1:0]      cur_ext;

	assign cur_ext = {1'b0, ctl.cursor};

	always_comb begin
		word_d = word_q;
		case (ctl.op)
			OP_INSERT: begin
				if (IDX == cur_ext) begin
					word_d = new_word;
				end else if (IDX > cur_ext && IDX <= ctl.count) begin
					word_d = prev_word;
				end
			end
			OP_APPEND: begin
				if (IDX == ctl.count) begin
					word_d = new_word;
				end
			end
			OP_REMOVE: begin
				if (IDX >= cur_ext && (IDX + CNT_W'(1)) < ctl.count) begin
					word_d = next_word;
				end
			end
			default: begin
				word_d = word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word = word_q;

endmodule

// ===== design/array_list_with_cursor_core.sv =====
// Top level of the bounded word list with cursor, built as a chain of cells.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall   cmd, value, position
//   out      source     out_valid / out_stall ok, word_out, count, cursor, empty_res, full_res
//
// The cells shift, load or hold in the cycle a command is accepted.
// The result appears in the output register in the cycle after acceptance.
// A new beat is taken every cycle unless a result waits with out_stall high.
// Reset clears the count, the cursor and the output valid; entries are not cleared.
// Entries at or beyond the count are never read.
`include "assert_macros.svh"

module array_list_with_cursor_core #(
	parameter int WORD_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [31:0] value,
	input  logic [3:0]  position,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [31:0] word_out,
	output logic [4:0]  count,
	output logic [3:0]  cursor,
	output logic        empty_res,
	output logic        full_res
);
	import alc_pkg::*;

	logic [CNT_W-1:0]      count_q;
	logic [POS_W-1:0]      cursor_q;
	logic                  out_valid_q;
	logic                  ok_q;
	logic [WORD_WIDTH-1:0] word_q;

	logic                  accept;
	logic                  full;
	logic                  cur_lt;
	logic [CNT_W-1:0]      cur_ext;
	logic [WORD_WIDTH-1:0] val_w;
	logic [WORD_WIDTH-1:0] cur_word;
	logic [WORD_WIDTH-1:0] word_a [CAPACITY];
	cell_ctl_t             ctl;
	logic [CNT_W-1:0]      count_d;
	logic [POS_W-1:0]      cursor_d;
	logic                  ok_d;
	logic [WORD_WIDTH-1:0] word_d;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = count_q == CNT_W'(CAPACITY);
	assign cur_ext  = {1'b0, cursor_q};
	assign cur_lt   = cur_ext < count_q;
	assign cur_word = word_a[cursor_q];

	generate
		if (WORD_WIDTH <= 32) begin : g_val_narrow
			assign val_w = value[WORD_WIDTH-1:0];
		end else begin : g_val_wide
			assign val_w = {{(WORD_WIDTH-32){1'b0}}, value};
		end
		if (WORD_WIDTH >= 32) begin : g_out_wide
			assign word_out = word_q[31:0];
		end else begin : g_out_narrow
			assign word_out = {{(32-WORD_WIDTH){1'b0}}, word_q};
		end
	endgenerate

	always_comb begin
		count_d  = count_q;
		cursor_d = cursor_q;
		ok_d     = 1'b0;
		word_d   = '0;
		ctl.op     = OP_HOLD;
		ctl.cursor = cursor_q;
		ctl.count  = count_q;
		case (cmd_t'(cmd))
			CMD_CLEAR: begin
				count_d  = '0;
				cursor_d = '0;
				ok_d     = 1'b1;
			end
			CMD_INSERT: begin
				if (!full) begin
					ctl.op  = OP_INSERT;
					count_d = count_q + CNT_W'(1);
					ok_d    = 1'b1;
				end
			end
			CMD_APPEND: begin
				if (!full) begin
					ctl.op  = OP_APPEND;
					count_d = count_q + CNT_W'(1);
					ok_d    = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (cur_lt) begin
					ctl.op  = OP_REMOVE;
					count_d = count_q - CNT_W'(1);
					ok_d    = 1'b1;
					word_d  = cur_word;
				end
			end
			CMD_NEXT: begin
				if ((cur_ext + CNT_W'(1)) < count_q) begin
					cursor_d = cursor_q + POS_W'(1);
				end
				ok_d = 1'b1;
			end
			CMD_PREV: begin
				if (cursor_q != '0) begin
					cursor_d = cursor_q - POS_W'(1);
				end
				ok_d = 1'b1;
			end
			CMD_SETPOS: begin
				if ({1'b0, position} < count_q) begin
					cursor_d = position;
					ok_d     = 1'b1;
				end
			end
			CMD_READ: begin
				if (cur_lt) begin
					ok_d   = 1'b1;
					word_d = cur_word;
				end
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
		if (!accept) begin
			ctl.op = OP_HOLD;
		end
	end

	generate
		for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
			logic [WORD_WIDTH-1:0] prev_w;
			logic [WORD_WIDTH-1:0] next_w;
			if (g == 0) begin : g_first
				assign prev_w = word_a[g];
			end else begin : g_prev
				assign prev_w = word_a[g-1];
			end
			if (g == CAPACITY - 1) begin : g_last
				assign next_w = word_a[g];
			end else begin : g_next
				assign next_w = word_a[g+1];
			end
			alc_cell #(
				.INDEX(g),
				.WORD_WIDTH(WORD_WIDTH)
			) u_cell (
				.clk(clk),
				.ctl(ctl),
				.new_word(val_w),
				.prev_word(prev_w),
				.next_word(next_w),
				.word(word_a[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				cursor_q    <= cursor_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q   <= ok_d;
			word_q <= word_d;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign count     = count_q;
	assign cursor    = cursor_q;
	assign empty_res = count_q == '0;
	assign full_res  = full;

	`ASSERT_NEVER(a_count_bound, count_q > CNT_W'(CAPACITY), "count exceeds capacity")
	`ASSERT_NEVER(a_cursor_bound, cur_ext > count_q, "cursor beyond count")
	`ASSERT_AT(a_append_grows, (accept && cmd == CMD_APPEND && !full) |=> (count_q == $past(count_q) + CNT_W'(1)), "append did not grow the list")
	`ASSERT_AT(a_refused_zero, (out_valid_q && !ok_q) |-> (word_q == '0), "refused command returned a word")

endmodule
